>>> rtl/cmd_pkg.sv
// Package for the contact matrix decoder: weapon codes, line map, timing constants
// and the per-side contact decode. Used by contact_matrix_decoder and its checker.
// No dependencies.
`default_nettype none

package cmd_pkg;

  // Weapon mode codes (code 3 is rejected)
  localparam logic [1:0] MODE_EPEE  = 2'd0;
  localparam logic [1:0] MODE_FOIL  = 2'd1;
  localparam logic [1:0] MODE_SABRE = 2'd2;

  // Expected driven source lines per phase
  localparam logic [2:0] SRC_A_EPEE  = 3'd0;
  localparam logic [2:0] SRC_A_OTHER = 3'd1;
  localparam logic [2:0] SRC_B_EPEE  = 3'd3;
  localparam logic [2:0] SRC_B_OTHER = 3'd4;
  localparam logic [2:0] SRC_C       = 3'd6;

  // Receiver line map: side base + 0 jacket, +1 tip/blade, +2 guard; bit 6 piste
  localparam logic [2:0] LEFT_BASE  = 3'd0;
  localparam logic [2:0] RIGHT_BASE = 3'd3;
  localparam logic [2:0] TIP_OFS    = 3'd1;
  localparam logic [2:0] GUARD_OFS  = 3'd2;
  localparam logic [2:0] PISTE_BIT  = 3'd6;
  localparam int unsigned SPARE_BIT = 7;

  // Phase spacing in microseconds
  localparam logic [63:0] GAP_B      = 64'd40;
  localparam logic [63:0] GAP_C      = 64'd80;
  localparam logic [63:0] TIME_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF - GAP_C;

  // Decoded contacts of one side, plus a reject flag for illegal wiring
  typedef struct packed {
    logic off_target;
    logic epee_tip_on;
    logic foil_tip_off;
    logic guard_lost;
    logic blade_touch;
    logic reject;
  } side_t;

  // A pair of phases is inconsistent if the connection is one-way, or if
  // connected phases report different masks.
  function automatic logic pair_bad(input logic [7:0] ms, input logic [7:0] mk,
                                    input logic [2:0] is, input logic [2:0] ik);
    logic fwd;
    logic rev;
    fwd = ms[ik];
    rev = mk[is];
    return (fwd != rev) || (fwd && (ms != mk));
  endfunction

  // Per-weapon reading of one side's mask
  function automatic side_t decode_side(input logic [7:0] m, input logic [1:0] mode,
                                        input logic [2:0] own, input logic [2:0] oth);
    side_t r;
    logic  self_guard;
    logic  oth_guard;
    logic  self_lame;
    logic  target;
    logic  blade;
    logic  piste;
    self_guard = m[own + GUARD_OFS];
    oth_guard  = m[oth + GUARD_OFS];
    self_lame  = m[own];
    target     = m[oth];
    blade      = oth_guard | m[oth + TIP_OFS];
    piste      = m[PISTE_BIT];
    r          = '0;
    r.off_target = 1'b1;
    case (mode)
      MODE_EPEE: begin
        // crossed wiring: touching opponent jacket or tip line
        r.reject      = target | m[oth + TIP_OFS];
        r.epee_tip_on = ~self_guard & ~oth_guard & ~piste & m[own + TIP_OFS];
      end
      MODE_FOIL: begin
        r.foil_tip_off = ~self_guard & ~self_lame & ~blade & ~piste;
        r.off_target   = ~target;
      end
      MODE_SABRE: begin
        r.reject      = blade & target;
        r.guard_lost  = ~self_guard;
        r.blade_touch = blade;
        r.off_target  = ~(target & self_guard & ~self_lame & ~piste);
      end
      default: begin
        r.reject = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/contact_matrix_decoder.sv
// Contact matrix decoder top level: input register, frame check and contact
// decode, result register. Depends on cmd_pkg.
`default_nettype none

// Decodes one three-phase scan frame per request into left/right contact
// states. Throughput is one request per clock while out_ready is not held
// low. A request passes two register stages, the input register and the
// result register, around the check logic, whose longest path is a 64-bit
// add and compare on the timestamps. A result waiting on out_ready holds the
// input register, so a full input register stops the next request. A frame
// that fails any check returns frame_valid 0, both off_target flags 1, others 0.
module contact_matrix_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_weapon_mode,
  input  wire logic [7:0]  in_source_a,
  input  wire logic [7:0]  in_source_b,
  input  wire logic [7:0]  in_source_c,
  input  wire logic [7:0]  in_mask_a,
  input  wire logic [7:0]  in_mask_b,
  input  wire logic [7:0]  in_mask_c,
  input  wire logic [63:0] in_time_a,
  input  wire logic [63:0] in_time_b,
  input  wire logic [63:0] in_time_c,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_frame_valid,
  output logic             out_left_off_target,
  output logic             out_left_epee_tip_on,
  output logic             out_left_foil_tip_off,
  output logic             out_left_guard_lost,
  output logic             out_left_blade_touch,
  output logic             out_right_off_target,
  output logic             out_right_epee_tip_on,
  output logic             out_right_foil_tip_off,
  output logic             out_right_guard_lost,
  output logic             out_right_blade_touch,
  output logic [63:0]      out_sample_time
);

  // stage control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;

  // input register
  logic [1:0]  mode_r;
  logic [7:0]  src_a_r, src_b_r, src_c_r;
  logic [7:0]  mask_a_r, mask_b_r, mask_c_r;
  logic [63:0] time_a_r, time_b_r, time_c_r;

  // result register
  logic          frame_valid_r;
  cmd_pkg::side_t left_r, right_r;
  logic [63:0]   sample_time_r;

  // decode signals
  logic          epee;
  logic [2:0]    idx_a, idx_b, idx_c;
  logic          mode_ok, src_ok, time_ok, mask_ok, frame_ok;
  cmd_pkg::side_t left_d, right_d;
  cmd_pkg::side_t side_dflt;

  // handshake: stage 1 moves on when the result register is free or drained
  assign s1_adv   = ~out_valid_r | out_ready;
  assign in_ready = ~s1_valid_r | s1_adv;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture request
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= in_weapon_mode;
      src_a_r  <= in_source_a;
      src_b_r  <= in_source_b;
      src_c_r  <= in_source_c;
      mask_a_r <= in_mask_a;
      mask_b_r <= in_mask_b;
      mask_c_r <= in_mask_c;
      time_a_r <= in_time_a;
      time_b_r <= in_time_b;
      time_c_r <= in_time_c;
    end
  end

  // frame consistency checks
  always_comb begin
    epee    = (mode_r == cmd_pkg::MODE_EPEE);
    mode_ok = (mode_r == cmd_pkg::MODE_EPEE) || (mode_r == cmd_pkg::MODE_FOIL) ||
              (mode_r == cmd_pkg::MODE_SABRE);
    idx_a   = epee ? cmd_pkg::SRC_A_EPEE : cmd_pkg::SRC_A_OTHER;
    idx_b   = epee ? cmd_pkg::SRC_B_EPEE : cmd_pkg::SRC_B_OTHER;
    idx_c   = cmd_pkg::SRC_C;
    src_ok  = (src_a_r == {5'd0, idx_a}) && (src_b_r == {5'd0, idx_b}) &&
              (src_c_r == {5'd0, idx_c});
    time_ok = (time_a_r <= cmd_pkg::TIME_LIMIT) &&
              (time_b_r == time_a_r + cmd_pkg::GAP_B) &&
              (time_c_r == time_a_r + cmd_pkg::GAP_C);
    // spare bit clear, own source seen, pairwise reciprocity and matching masks
    mask_ok = ~mask_a_r[cmd_pkg::SPARE_BIT] & ~mask_b_r[cmd_pkg::SPARE_BIT] &
              ~mask_c_r[cmd_pkg::SPARE_BIT] &
              mask_a_r[idx_a] & mask_b_r[idx_b] & mask_c_r[idx_c] &
              ~cmd_pkg::pair_bad(mask_a_r, mask_b_r, idx_a, idx_b) &
              ~cmd_pkg::pair_bad(mask_a_r, mask_c_r, idx_a, idx_c) &
              ~cmd_pkg::pair_bad(mask_b_r, mask_c_r, idx_b, idx_c);
  end

  // per-side decode: left reads phase one, right reads phase two
  assign left_d  = cmd_pkg::decode_side(mask_a_r, mode_r, cmd_pkg::LEFT_BASE,
                                        cmd_pkg::RIGHT_BASE);
  assign right_d = cmd_pkg::decode_side(mask_b_r, mode_r, cmd_pkg::RIGHT_BASE,
                                        cmd_pkg::LEFT_BASE);

  assign frame_ok = mode_ok & src_ok & time_ok & mask_ok & ~left_d.reject &
                    ~right_d.reject;

  always_comb begin
    side_dflt            = '0;
    side_dflt.off_target = 1'b1;
  end

  // load result
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      frame_valid_r <= frame_ok;
      left_r        <= frame_ok ? left_d : side_dflt;
      right_r       <= frame_ok ? right_d : side_dflt;
      sample_time_r <= frame_ok ? time_c_r : 64'd0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_frame_valid        = frame_valid_r;
  assign out_left_off_target    = left_r.off_target;
  assign out_left_epee_tip_on   = left_r.epee_tip_on;
  assign out_left_foil_tip_off  = left_r.foil_tip_off;
  assign out_left_guard_lost    = left_r.guard_lost;
  assign out_left_blade_touch   = left_r.blade_touch;
  assign out_right_off_target   = right_r.off_target;
  assign out_right_epee_tip_on  = right_r.epee_tip_on;
  assign out_right_foil_tip_off = right_r.foil_tip_off;
  assign out_right_guard_lost   = right_r.guard_lost;
  assign out_right_blade_touch  = right_r.blade_touch;
  assign out_sample_time        = sample_time_r;

endmodule

`default_nettype wire

>>> rtl/cmd_checker.sv
// Port-level checker for contact_matrix_decoder, bound to the top level.
// Depends on cmd_pkg.
`default_nettype none

module cmd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_frame_valid,
  input wire logic        out_left_off_target,
  input wire logic        out_left_epee_tip_on,
  input wire logic        out_left_foil_tip_off,
  input wire logic        out_left_guard_lost,
  input wire logic        out_left_blade_touch,
  input wire logic        out_right_off_target,
  input wire logic        out_right_epee_tip_on,
  input wire logic        out_right_foil_tip_off,
  input wire logic        out_right_guard_lost,
  input wire logic        out_right_blade_touch,
  input wire logic [63:0] out_sample_time
);

  logic epee_any, other_any;
  assign epee_any  = out_left_epee_tip_on | out_right_epee_tip_on;
  assign other_any = out_left_foil_tip_off | out_right_foil_tip_off |
                     out_left_guard_lost | out_right_guard_lost |
                     out_left_blade_touch | out_right_blade_touch;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_time) &&
    $stable(out_frame_valid))
    else $error("result changed while stalled");

  // rejected frame carries the default result
  a_reject_dflt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_valid |-> out_left_off_target && out_right_off_target &&
    !epee_any && !other_any && (out_sample_time == 64'd0))
    else $error("rejected frame without default result");

  // contacts of only one weapon family show at once
  a_one_weapon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(epee_any && other_any))
    else $error("epee and foil/sabre contacts together");

  // accepted frame time is the third phase, so at least the full spacing
  a_time_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_valid |-> out_sample_time >= cmd_pkg::GAP_C)
    else $error("accepted frame with impossible sample time");

endmodule

bind contact_matrix_decoder cmd_checker u_cmd_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_frame_valid        (out_frame_valid),
  .out_left_off_target    (out_left_off_target),
  .out_left_epee_tip_on   (out_left_epee_tip_on),
  .out_left_foil_tip_off  (out_left_foil_tip_off),
  .out_left_guard_lost    (out_left_guard_lost),
  .out_left_blade_touch   (out_left_blade_touch),
  .out_right_off_target   (out_right_off_target),
  .out_right_epee_tip_on  (out_right_epee_tip_on),
  .out_right_foil_tip_off (out_right_foil_tip_off),
  .out_right_guard_lost   (out_right_guard_lost),
  .out_right_blade_touch  (out_right_blade_touch),
  .out_sample_time        (out_sample_time)
);

`default_nettype wire
